[hdl/lrc_pkg.sv]
// Shared types and constants for the recency-ordered result cache.
package lrc_pkg;

    localparam int TAG_W     = 64;
    localparam int PAYLOAD_W = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                 any_match;
        logic [PAYLOAD_W-1:0] found;
    } chain_t;

    typedef struct packed {
        logic capture;
        logic apply;
        op_t  op;
        logic hit_any;
    } cell_ctrl_t;

endpackage

[hdl/lrc_cell.sv]
// One list position: holds an entry, compares its tag and shifts along the chain.
module lrc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrc_pkg::cell_ctrl_t            ctrl,
    input  logic [lrc_pkg::TAG_W-1:0]      key,
    input  logic [lrc_pkg::PAYLOAD_W-1:0]  new_payload,
    input  lrc_pkg::entry_t                prev,
    input  lrc_pkg::chain_t                tail_in,
    output lrc_pkg::entry_t                entry,
    output lrc_pkg::chain_t                tail_out,
    output logic                           match
);
    import lrc_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [TAG_W-1:0]     tag_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 any_ge;

    assign any_ge             = match_reg | tail_in.any_match;
    assign tail_out.any_match = any_ge;
    assign tail_out.found     = tail_in.found | (match_reg ? payload_reg : '0);

    assign entry.valid   = valid_reg;
    assign entry.tag     = tag_reg;
    assign entry.payload = payload_reg;
    assign match         = match_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        tag_next     = tag_reg;
        payload_next = payload_reg;
        match_next   = match_reg;
        if (ctrl.capture)
        begin
            match_next = valid_reg && (tag_reg == key);
        end
        if (ctrl.apply)
        begin
            case (ctrl.op)
                OP_LOOKUP:
                begin
                    if (any_ge)
                    begin
                        valid_next   = prev.valid;
                        tag_next     = prev.tag;
                        payload_next = prev.payload;
                    end
                end
                OP_STORE:
                begin
                    if (ctrl.hit_any)
                    begin
                        if (match_reg)
                        begin
                            payload_next = new_payload;
                        end
                    end
                    else
                    begin
                        valid_next   = prev.valid;
                        tag_next     = prev.tag;
                        payload_next = prev.payload;
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        payload_reg <= payload_next;
    end

endmodule

[hdl/lru_result_cache.sv]
// Top level: control sequencer and output register around the chain of list cells.
// An accepted transaction is registered and its tag compared in the compare cycle (S_IDLE);
// the shift cycle (S_APPLY) then writes its result to the output register, and waits while
// an earlier result still holds the output register. New transactions are taken only in
// S_IDLE (in_stall is high in S_APPLY), so each waits for the shift cycle of the one before.
// Reset: all list positions invalid (empty list), no result pending; tags and payloads
// in the list cells are not cleared.
module lru_result_cache #(
    parameter int CAPACITY = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [lrc_pkg::TAG_W-1:0]      tag,
    input  logic [lrc_pkg::PAYLOAD_W-1:0]  payload,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [lrc_pkg::PAYLOAD_W-1:0]  found_payload
);
    import lrc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [PAYLOAD_W-1:0] found_reg;

    logic       accept;
    logic       apply_fire;
    logic       lookup_hit;
    cell_ctrl_t ctrl;
    entry_t     head;
    entry_t     ent   [CAPACITY];
    chain_t     chain [CAPACITY+1];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] match_vec;

    assign in_stall   = (state_reg == S_APPLY);
    assign accept     = in_valid && !in_stall;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);

    assign ctrl.capture = accept;
    assign ctrl.apply   = apply_fire;
    assign ctrl.op      = op_reg;
    assign ctrl.hit_any = chain[0].any_match;

    assign lookup_hit = (op_reg == OP_LOOKUP) && chain[0].any_match;

    assign head.valid   = 1'b1;
    assign head.tag     = tag_reg;
    assign head.payload = (op_reg == OP_LOOKUP) ? chain[0].found : payload_reg;

    assign chain[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_entry;
        if (i == 0)
        begin : g_head
            assign prev_entry = head;
        end
        else
        begin : g_body
            assign prev_entry = ent[i-1];
        end
        lrc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (tag),
            .new_payload (payload_reg),
            .prev        (prev_entry),
            .tail_in     (chain[i+1]),
            .entry       (ent[i]),
            .tail_out    (chain[i]),
            .match       (match_vec[i])
        );
        assign valid_vec[i] = ent[i].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_LOOKUP;
            tag_reg       <= '0;
            payload_reg   <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= op_t'(operation);
                        tag_reg     <= tag;
                        payload_reg <= payload;
                        state_reg   <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (apply_fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (apply_fire)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= lookup_hit;
                found_reg     <= lookup_hit ? chain[0].found : '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign found_payload = found_reg;

    a_single_match : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(match_vec))
        else $error("more than one list position matches the tag");

    a_valid_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("valid positions do not form a prefix of the list");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && op_reg == OP_CLEAR) |=> (valid_vec == '0))
        else $error("clear left valid positions");

    a_insert_front : assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && op_reg == OP_STORE && !chain[0].any_match)
        |=> (ent[0].valid && ent[0].tag == $past(tag_reg)))
        else $error("new tag not placed at the front");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> out_valid_reg)
        else $error("result lost after shift cycle");

endmodule
